@@ hdl/kvca_pkg.sv @@
package kvca_pkg;

    // Sizes of the stores
    localparam int MAX_TOKENS = 512;
    localparam int MAX_DIM    = 64;
    localparam int QUERY_ROWS = 4;

    localparam int TOK_W   = $clog2(MAX_TOKENS);
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ROW_W   = $clog2(QUERY_ROWS);
    localparam int QMEM_AW = ROW_W + DIM_W;
    localparam int KV_AW   = TOK_W + DIM_W;

    // Data widths
    localparam int ELEM_W   = 16;                  // Q1.15 element
    localparam int SCORE_W  = 16;                  // Q8.8 score
    localparam int EXP_W    = 16;                  // Q0.16 table entry
    localparam int WGT_W    = 17;                  // Q1.16 weight
    localparam int WGT_FRAC = 16;
    localparam int NUM_W    = EXP_W + WGT_FRAC;    // term << 16
    localparam int QUO_W    = WGT_W;
    localparam int SUM_W    = EXP_W + TOK_W;       // sum of all terms
    localparam int ACC_W    = 42;                  // sum of weight*value products
    localparam int MA_W     = 20;                  // shared multiplier, operand a
    localparam int MB_W     = 18;                  // shared multiplier, operand b
    localparam int MUL_W    = MA_W + MB_W;
    localparam int DOT_W    = 38;                  // Q8.30 dot product
    localparam int SPLIT    = 19;                  // dot split into hi and lo halves
    localparam int LO_W     = SPLIT + 16;
    localparam int FULL_W   = DOT_W + 19;
    localparam int SCORE_SH = 38;

    localparam int TC_W = 10;
    localparam int DC_W = 7;
    localparam int SF_W = 16;

    typedef enum logic [1:0] {
        OP_LOAD_Q = 2'd0,
        OP_LOAD_K = 2'd1,
        OP_LOAD_V = 2'd2,
        OP_RUN    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_TOKEN_COUNT = 2'd0,
        CFG_DIM_COUNT   = 2'd1,
        CFG_SCALE       = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOT_RD,
        S_DOT_MUL,
        S_DOT_ACC,
        S_SC_LO,
        S_SC_HI,
        S_SC_FIN,
        S_EXP_RD,
        S_EXP_WR,
        S_DIV_RD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT_RD,
        S_OUT_MUL,
        S_OUT_ACC,
        S_OUT_EMIT
    } state_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

    typedef logic [EXP_W-1:0] exp_tab_t [256];

    // exp(-i/16) in Q0.16, evaluated at elaboration
    function automatic exp_tab_t build_exp_table();
        exp_tab_t    tab;
        logic [63:0] a;
        logic [63:0] e;
        a = 64'd1 << 32;
        for (int i = 0; i < 256; i++) begin
            e = (a + 64'd32768) >> 16;
            tab[i] = (e > 64'd65535) ? 16'hFFFF : e[EXP_W-1:0];
            a = (a * 64'd4034748382 + 64'd2147483648) >> 32;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

@@ hdl/kvca_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Requires num >> QUO_W < den so the quotient fits QUO_W bits.
module kvca_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [kvca_pkg::NUM_W-1:0]   num,
    input  logic [kvca_pkg::SUM_W-1:0]   den,
    output kvca_pkg::div_rsp_t           rsp
);

    localparam int CNT_W = $clog2(kvca_pkg::QUO_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [kvca_pkg::SUM_W-1:0]   rem_reg, rem_next;
    logic [kvca_pkg::SUM_W-1:0]   den_reg, den_next;
    logic [kvca_pkg::QUO_W-1:0]   shf_reg, shf_next;

    logic [kvca_pkg::SUM_W:0]     trial;
    logic [kvca_pkg::SUM_W:0]     diff;
    logic                         ge;

    // One subtract-and-compare step
    always_comb
    begin
        trial = {rem_reg, shf_reg[kvca_pkg::QUO_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        shf_next  = shf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = kvca_pkg::SUM_W'(num[kvca_pkg::NUM_W-1:kvca_pkg::QUO_W]);
            shf_next  = num[kvca_pkg::QUO_W-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[kvca_pkg::SUM_W-1:0] : trial[kvca_pkg::SUM_W-1:0];
            shf_next = {shf_reg[kvca_pkg::QUO_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(kvca_pkg::QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        shf_reg <= shf_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = shf_reg;

endmodule

@@ hdl/kv_cache_attention.sv @@
// Load items do not stall the input; the block stays ready after each one.
// During a run, one shared multiplier handles every product and the divider
// normalizes each token's weight; no item is taken meanwhile.
// Reset (async, active low) returns to idle with token_count 512, dim_count 64,
// scale_factor 8192; the stores are not cleared and must be loaded before use.
module kv_cache_attention (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [15:0]                        cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [1:0]                         row,
    input  logic [8:0]                         token,
    input  logic [5:0]                         dim,
    input  logic signed [15:0]                 value,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         out_row,
    output logic [5:0]                         out_dim,
    output logic signed [15:0]                 out_value,
    output logic                               last
);

    // Configuration registers
    logic [kvca_pkg::TC_W-1:0] token_count_reg;
    logic [kvca_pkg::DC_W-1:0] dim_count_reg;
    logic [kvca_pkg::SF_W-1:0] scale_reg;

    // Sequencer and datapath registers
    kvca_pkg::state_t                  state_reg, state_next;
    logic [kvca_pkg::ROW_W-1:0]        row_reg, row_next;
    logic [kvca_pkg::TOK_W-1:0]        tn_m1_reg, tn_m1_next;
    logic [kvca_pkg::DIM_W-1:0]        dn_m1_reg, dn_m1_next;
    logic [kvca_pkg::TOK_W-1:0]        t_reg, t_next;
    logic [kvca_pkg::DIM_W-1:0]        d_reg, d_next;
    logic signed [kvca_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic signed [kvca_pkg::MUL_W-1:0] mul_reg, mul_next;
    logic [kvca_pkg::LO_W-1:0]         lo_reg, lo_next;
    logic signed [kvca_pkg::SCORE_W-1:0] max_reg, max_next;
    logic [kvca_pkg::SUM_W-1:0]        sum_reg, sum_next;

    logic                              out_valid_reg, out_valid_next;
    logic [1:0]                        out_row_reg, out_row_next;
    logic [5:0]                        out_dim_reg, out_dim_next;
    logic signed [15:0]                out_value_reg, out_value_next;
    logic                              last_reg, last_next;

    // Stores
    logic signed [kvca_pkg::ELEM_W-1:0] q_mem [2**kvca_pkg::QMEM_AW];
    logic signed [kvca_pkg::ELEM_W-1:0] k_mem [2**kvca_pkg::KV_AW];
    logic signed [kvca_pkg::ELEM_W-1:0] v_mem [2**kvca_pkg::KV_AW];
    logic [kvca_pkg::WGT_W-1:0]         w_mem [kvca_pkg::MAX_TOKENS];

    logic signed [kvca_pkg::ELEM_W-1:0] q_rd, k_rd, v_rd;
    logic [kvca_pkg::WGT_W-1:0]         w_rd;

    logic                               accept;
    logic                               load_ok;
    logic                               q_we, k_we, v_we;
    logic [kvca_pkg::QMEM_AW-1:0]       q_waddr, q_raddr;
    logic [kvca_pkg::KV_AW-1:0]         kv_waddr, kv_raddr;
    logic                               w_we;
    logic [kvca_pkg::WGT_W-1:0]         w_wdata;

    logic signed [kvca_pkg::MA_W-1:0]   ma;
    logic signed [kvca_pkg::MB_W-1:0]   mb;
    logic signed [kvca_pkg::FULL_W-1:0] sc_full;
    logic signed [kvca_pkg::SCORE_W-1:0] score;
    logic signed [kvca_pkg::SCORE_W-1:0] w_score;
    logic signed [kvca_pkg::SCORE_W:0]  diff;
    logic [kvca_pkg::EXP_W-1:0]         term;
    logic signed [kvca_pkg::ACC_W-16-1:0] res_full;
    logic signed [15:0]                 res_sat;
    logic                               run_start;
    logic                               t_last, d_last, emit_ok;
    logic [kvca_pkg::TOK_W-1:0]         tn_m1_cfg;
    logic [kvca_pkg::DIM_W-1:0]         dn_m1_cfg;

    logic                               div_start;
    logic [kvca_pkg::NUM_W-1:0]         div_num;
    kvca_pkg::div_rsp_t                 div_rsp;

    // Handshakes
    assign in_stall = (state_reg != kvca_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign emit_ok  = !out_valid_reg || !out_stall;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_count_reg <= kvca_pkg::TC_W'(512);
            dim_count_reg   <= kvca_pkg::DC_W'(64);
            scale_reg       <= kvca_pkg::SF_W'(8192);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kvca_pkg::CFG_TOKEN_COUNT: token_count_reg <= cfg_data[kvca_pkg::TC_W-1:0];
                kvca_pkg::CFG_DIM_COUNT:   dim_count_reg   <= cfg_data[kvca_pkg::DC_W-1:0];
                kvca_pkg::CFG_SCALE:       scale_reg       <= cfg_data[kvca_pkg::SF_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped counts, minus one
    always_comb
    begin
        if (token_count_reg == '0)
            tn_m1_cfg = '0;
        else if (32'(token_count_reg) > kvca_pkg::MAX_TOKENS)
            tn_m1_cfg = kvca_pkg::TOK_W'(kvca_pkg::MAX_TOKENS - 1);
        else
            tn_m1_cfg = kvca_pkg::TOK_W'(token_count_reg - 1'b1);
        if (dim_count_reg == '0)
            dn_m1_cfg = '0;
        else if (32'(dim_count_reg) > kvca_pkg::MAX_DIM)
            dn_m1_cfg = kvca_pkg::DIM_W'(kvca_pkg::MAX_DIM - 1);
        else
            dn_m1_cfg = kvca_pkg::DIM_W'(dim_count_reg - 1'b1);
    end

    // Load decode
    always_comb
    begin
        load_ok  = (32'(dim) < kvca_pkg::MAX_DIM);
        q_we     = accept && load_ok && (operation == kvca_pkg::OP_LOAD_Q)
                   && (32'(row) < kvca_pkg::QUERY_ROWS);
        k_we     = accept && load_ok && (operation == kvca_pkg::OP_LOAD_K)
                   && (32'(token) < kvca_pkg::MAX_TOKENS);
        v_we     = accept && load_ok && (operation == kvca_pkg::OP_LOAD_V)
                   && (32'(token) < kvca_pkg::MAX_TOKENS);
        run_start = accept && (operation == kvca_pkg::OP_RUN)
                   && (32'(row) < kvca_pkg::QUERY_ROWS);
        q_waddr  = {row[kvca_pkg::ROW_W-1:0], dim[kvca_pkg::DIM_W-1:0]};
        kv_waddr = {token[kvca_pkg::TOK_W-1:0], dim[kvca_pkg::DIM_W-1:0]};
        q_raddr  = {row_reg, d_reg};
        kv_raddr = {t_reg, d_reg};
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_waddr] <= value;
        q_rd <= q_mem[q_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (k_we)
            k_mem[kv_waddr] <= value;
        k_rd <= k_mem[kv_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            v_mem[kv_waddr] <= value;
        v_rd <= v_mem[kv_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[t_reg] <= w_wdata;
        w_rd <= w_mem[t_reg];
    end

    // Shared multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            kvca_pkg::S_DOT_MUL:
            begin
                ma = kvca_pkg::MA_W'(q_rd);
                mb = kvca_pkg::MB_W'(k_rd);
            end
            kvca_pkg::S_SC_LO:
            begin
                ma = $signed(kvca_pkg::MA_W'(acc_reg[kvca_pkg::SPLIT-1:0]));
                mb = $signed(kvca_pkg::MB_W'(scale_reg));
            end
            kvca_pkg::S_SC_HI:
            begin
                ma = kvca_pkg::MA_W'($signed(acc_reg[kvca_pkg::DOT_W-1:kvca_pkg::SPLIT]));
                mb = $signed(kvca_pkg::MB_W'(scale_reg));
            end
            kvca_pkg::S_OUT_MUL:
            begin
                ma = $signed(kvca_pkg::MA_W'(w_rd));
                mb = kvca_pkg::MB_W'(v_rd);
            end
            default: ;
        endcase
    end

    // Score, exponent term and output saturation
    always_comb
    begin
        sc_full = (kvca_pkg::FULL_W'(mul_reg) <<< kvca_pkg::SPLIT)
                  + $signed(kvca_pkg::FULL_W'(lo_reg));
        score   = sc_full[kvca_pkg::SCORE_SH+kvca_pkg::SCORE_W-1:kvca_pkg::SCORE_SH];
        w_score = $signed(w_rd[kvca_pkg::SCORE_W-1:0]);
        diff    = {max_reg[kvca_pkg::SCORE_W-1], max_reg}
                  - {w_score[kvca_pkg::SCORE_W-1], w_score};
        term    = (diff[kvca_pkg::SCORE_W:12] == '0) ? kvca_pkg::EXP_TABLE[diff[11:4]] : '0;
        res_full = acc_reg[kvca_pkg::ACC_W-1:16];
        if (res_full > $signed(26'sd32767))
            res_sat = 16'sh7FFF;
        else if (res_full < -$signed(26'sd32768))
            res_sat = -16'sh8000;
        else
            res_sat = res_full[15:0];
        t_last = (t_reg == tn_m1_reg);
        d_last = (d_reg == dn_m1_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kvca_pkg::S_IDLE:     if (run_start) state_next = kvca_pkg::S_DOT_RD;
            kvca_pkg::S_DOT_RD:   state_next = kvca_pkg::S_DOT_MUL;
            kvca_pkg::S_DOT_MUL:  state_next = kvca_pkg::S_DOT_ACC;
            kvca_pkg::S_DOT_ACC:  state_next = d_last ? kvca_pkg::S_SC_LO : kvca_pkg::S_DOT_RD;
            kvca_pkg::S_SC_LO:    state_next = kvca_pkg::S_SC_HI;
            kvca_pkg::S_SC_HI:    state_next = kvca_pkg::S_SC_FIN;
            kvca_pkg::S_SC_FIN:   state_next = t_last ? kvca_pkg::S_EXP_RD : kvca_pkg::S_DOT_RD;
            kvca_pkg::S_EXP_RD:   state_next = kvca_pkg::S_EXP_WR;
            kvca_pkg::S_EXP_WR:   state_next = t_last ? kvca_pkg::S_DIV_RD : kvca_pkg::S_EXP_RD;
            kvca_pkg::S_DIV_RD:   state_next = kvca_pkg::S_DIV_GO;
            kvca_pkg::S_DIV_GO:   state_next = kvca_pkg::S_DIV_WAIT;
            kvca_pkg::S_DIV_WAIT:
                if (div_rsp.done)
                    state_next = t_last ? kvca_pkg::S_OUT_RD : kvca_pkg::S_DIV_RD;
            kvca_pkg::S_OUT_RD:   state_next = kvca_pkg::S_OUT_MUL;
            kvca_pkg::S_OUT_MUL:  state_next = kvca_pkg::S_OUT_ACC;
            kvca_pkg::S_OUT_ACC:  state_next = t_last ? kvca_pkg::S_OUT_EMIT : kvca_pkg::S_OUT_RD;
            kvca_pkg::S_OUT_EMIT:
                if (emit_ok)
                    state_next = d_last ? kvca_pkg::S_IDLE : kvca_pkg::S_OUT_RD;
            default:              state_next = kvca_pkg::S_IDLE;
        endcase
    end

    // Datapath controls
    always_comb
    begin
        row_next       = row_reg;
        tn_m1_next     = tn_m1_reg;
        dn_m1_next     = dn_m1_reg;
        t_next         = t_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        mul_next       = ma * mb;
        lo_next        = lo_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        w_we           = 1'b0;
        w_wdata        = div_rsp.quo;
        div_start      = 1'b0;
        div_num        = {w_rd[kvca_pkg::EXP_W-1:0], kvca_pkg::WGT_FRAC'(0)};
        out_valid_next = out_valid_reg && out_stall;
        out_row_next   = out_row_reg;
        out_dim_next   = out_dim_reg;
        out_value_next = out_value_reg;
        last_next      = last_reg;
        unique case (state_reg)
            kvca_pkg::S_IDLE:
                if (run_start)
                begin
                    row_next   = row[kvca_pkg::ROW_W-1:0];
                    tn_m1_next = tn_m1_cfg;
                    dn_m1_next = dn_m1_cfg;
                    t_next     = '0;
                    d_next     = '0;
                    acc_next   = '0;
                    sum_next   = '0;
                end
            kvca_pkg::S_DOT_ACC:
            begin
                acc_next = acc_reg + kvca_pkg::ACC_W'(mul_reg);
                if (!d_last)
                    d_next = d_reg + 1'b1;
            end
            kvca_pkg::S_SC_HI:
                lo_next = mul_reg[kvca_pkg::LO_W-1:0];
            kvca_pkg::S_SC_FIN:
            begin
                w_we    = 1'b1;
                w_wdata = kvca_pkg::WGT_W'(score);
                if ((t_reg == '0) || (score > max_reg))
                    max_next = score;
                acc_next = '0;
                d_next   = '0;
                t_next   = t_last ? '0 : t_reg + 1'b1;
            end
            kvca_pkg::S_EXP_WR:
            begin
                w_we     = 1'b1;
                w_wdata  = kvca_pkg::WGT_W'(term);
                sum_next = sum_reg + kvca_pkg::SUM_W'(term);
                t_next   = t_last ? '0 : t_reg + 1'b1;
            end
            kvca_pkg::S_DIV_GO:
                div_start = 1'b1;
            kvca_pkg::S_DIV_WAIT:
                if (div_rsp.done)
                begin
                    w_we     = 1'b1;
                    w_wdata  = div_rsp.quo;
                    t_next   = t_last ? '0 : t_reg + 1'b1;
                    d_next   = '0;
                    acc_next = '0;
                end
            kvca_pkg::S_OUT_ACC:
            begin
                acc_next = acc_reg + kvca_pkg::ACC_W'(mul_reg);
                if (!t_last)
                    t_next = t_reg + 1'b1;
            end
            kvca_pkg::S_OUT_EMIT:
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = 2'(row_reg);
                    out_dim_next   = 6'(d_reg);
                    out_value_next = res_sat;
                    last_next      = d_last;
                    t_next         = '0;
                    acc_next       = '0;
                    if (!d_last)
                        d_next = d_reg + 1'b1;
                end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvca_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        tn_m1_reg     <= tn_m1_next;
        dn_m1_reg     <= dn_m1_next;
        t_reg         <= t_next;
        d_reg         <= d_next;
        acc_reg       <= acc_next;
        mul_reg       <= mul_next;
        lo_reg        <= lo_next;
        max_reg       <= max_next;
        sum_reg       <= sum_next;
        out_row_reg   <= out_row_next;
        out_dim_reg   <= out_dim_next;
        out_value_reg <= out_value_next;
        last_reg      <= last_next;
    end

    // Weight normalization divider
    kvca_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sum_reg),
        .rsp   (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_dim   = out_dim_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

    // Divider runs only while the sequencer waits on it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != kvca_pkg::S_DIV_WAIT) |-> !div_rsp.busy)
        else $error("divider busy outside its wait state");

    // The sum always holds the maximum's full term before normalizing
    a_sum_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kvca_pkg::S_DIV_GO) |-> (sum_reg >= kvca_pkg::SUM_W'(65535)))
        else $error("term sum below the maximum's term");

    // A new output element only comes from the emit step
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == kvca_pkg::S_OUT_EMIT))
        else $error("output valid raised outside the emit step");

endmodule
